/* sv/cpbc_pkg.sv */
`default_nettype none

package cpbc_pkg;

    // Scheduling and number format
    localparam int VELOCITY_PERIOD = 50;
    localparam int ANGLE_PERIOD    = 5;
    localparam int FRAC_BITS       = 8;
    localparam int GAIN_FRAC       = 8;

    localparam int TICK_W  = 6;
    localparam int PHASE_W = $clog2(ANGLE_PERIOD + 1);

    // Field widths
    localparam int WORD_W     = 32;
    localparam int GAINS_W    = 48;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int ANGLE_W    = 17;
    localparam int GYRO_W     = 16;
    localparam int WHEEL_W    = 16;
    localparam int DRIVE_W    = 24;
    localparam int CFG_ADDR_W = 3;

    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
    localparam int DRIVE_MAX = (1 << (DRIVE_W - 1)) - 1;
    localparam int DRIVE_MIN = -(1 << (DRIVE_W - 1));

    localparam logic signed [WORD_W-1:0]  S32_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0]  S32_MIN       = 32'sh8000_0000;
    localparam logic signed [ANGLE_W-1:0] BALANCE_RESET = -17'sd102;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_VEL_GAINS  = 3'd0,
        REG_ANG_GAINS  = 3'd1,
        REG_RATE_GAINS = 3'd2,
        REG_VEL_LIMIT  = 3'd3,
        REG_ANG_LIMIT  = 3'd4,
        REG_RATE_LIMIT = 3'd5,
        REG_BALANCE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LOOP_VEL  = 2'd0,
        LOOP_ANG  = 2'd1,
        LOOP_RATE = 2'd2
    } loop_t;

    typedef enum logic [1:0] {
        ALU_ADD   = 2'd0,
        ALU_SUB   = 2'd1,
        ALU_MUL   = 2'd2,
        ALU_CLAMP = 2'd3
    } alu_op_t;

    // Saturate a 33-bit sum to signed 32 bits
    function automatic logic signed [WORD_W-1:0] sat33(input logic signed [WORD_W:0] v);
        logic signed [WORD_W-1:0] r;
        if (v[WORD_W] != v[WORD_W-1]) begin
            r = v[WORD_W] ? S32_MIN : S32_MAX;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cpbc_alu.sv */
`default_nettype none

// Shared saturating add/sub, gain multiply and integrator clamp.
module cpbc_alu (
    input  cpbc_pkg::alu_op_t                   op,
    input  logic signed [cpbc_pkg::WORD_W-1:0]  a,
    input  logic signed [cpbc_pkg::WORD_W-1:0]  b,
    input  logic signed [cpbc_pkg::GAIN_W-1:0]  gain,
    input  logic        [cpbc_pkg::LIMIT_W-1:0] lim,
    output logic signed [cpbc_pkg::WORD_W-1:0]  y
);

    localparam int PROD_W = cpbc_pkg::WORD_W + cpbc_pkg::GAIN_W;

    logic signed [cpbc_pkg::WORD_W:0] sum;
    logic signed [cpbc_pkg::WORD_W:0] a_ext;
    logic signed [cpbc_pkg::WORD_W:0] lim_pos;
    logic signed [cpbc_pkg::WORD_W:0] lim_neg;
    logic signed [PROD_W-1:0]         prod;
    logic signed [PROD_W-1:0]         prod_sh;
    logic signed [cpbc_pkg::WORD_W-1:0] term;
    logic signed [cpbc_pkg::WORD_W-1:0] clamped;

    always_comb begin
        a_ext = (cpbc_pkg::WORD_W + 1)'(a);
        if (op == cpbc_pkg::ALU_SUB) begin
            sum = a_ext - (cpbc_pkg::WORD_W + 1)'(b);
        end else begin
            sum = a_ext + (cpbc_pkg::WORD_W + 1)'(b);
        end

        // floor(gain * a / 256), saturated
        prod    = PROD_W'(a) * PROD_W'(gain);
        prod_sh = prod >>> cpbc_pkg::GAIN_FRAC;
        if (prod_sh > PROD_W'(cpbc_pkg::S32_MAX)) begin
            term = cpbc_pkg::S32_MAX;
        end else if (prod_sh < PROD_W'(cpbc_pkg::S32_MIN)) begin
            term = cpbc_pkg::S32_MIN;
        end else begin
            term = prod_sh[cpbc_pkg::WORD_W-1:0];
        end

        lim_pos = signed'({2'b00, lim});
        lim_neg = -lim_pos;
        if (a_ext > lim_pos) begin
            clamped = lim_pos[cpbc_pkg::WORD_W-1:0];
        end else if (a_ext < lim_neg) begin
            clamped = lim_neg[cpbc_pkg::WORD_W-1:0];
        end else begin
            clamped = a;
        end

        unique case (op)
            cpbc_pkg::ALU_ADD,
            cpbc_pkg::ALU_SUB:   y = cpbc_pkg::sat33(sum);
            cpbc_pkg::ALU_MUL:   y = term;
            cpbc_pkg::ALU_CLAMP: y = clamped;
            default:             y = a;
        endcase
    end

endmodule

`default_nettype wire

/* sv/cascade_pid_balance_controller_unit.sv */
`default_nettype none

// Cascaded three-loop PID balance controller. Each request on the s_ side is one
// control tick (roll angle, gyro rate, wheel count); each tick yields exactly one
// result on the m_ side (drive plus flags telling whether the velocity and angle
// loops ran). The velocity loop runs every 50th tick, the angle loop every 5th
// tick (always on a velocity tick), the rate loop every tick. All loop math goes
// through one shared ALU (saturating add/sub, 32x16 gain multiply, clamp), one
// step per cycle under a small sequencer; each loop takes 9 steps (10 for the
// angle loop, whose error needs two adds). s_tready returns after the last loop of
// the tick has run and its result has gone to the output register; that handover
// waits only while the previous result is still held in the output register.
// s_tready is low while a tick is being worked. Configuration writes go through
// cfg_wr_en/cfg_addr/cfg_wr_data and must only be issued while the block is idle.
module cascade_pid_balance_controller_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [16:0] roll_angle, [32:17] gyro_rate, [48:33] wheel_count, [55:49] zero
    input  wire logic [55:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [23:0] drive, [24] velocity_ran, [25] angle_ran, [31:26] zero
    output logic [31:0]      m_tdata,

    input  wire logic                            cfg_wr_en,
    input  wire logic [cpbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [cpbc_pkg::GAINS_W-1:0]    cfg_wr_data
);

    localparam int W  = cpbc_pkg::WORD_W;
    localparam int GW = cpbc_pkg::GAIN_W;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_ERR_A  = 12'b0000_0000_0010,
        ST_ERR_B  = 12'b0000_0000_0100,
        ST_INTEG  = 12'b0000_0000_1000,
        ST_CLAMP  = 12'b0000_0001_0000,
        ST_DIFF   = 12'b0000_0010_0000,
        ST_TERM_P = 12'b0000_0100_0000,
        ST_TERM_I = 12'b0000_1000_0000,
        ST_SUM_PI = 12'b0001_0000_0000,
        ST_TERM_D = 12'b0010_0000_0000,
        ST_SUM_D  = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    // Control state
    state_t                        state_reg, state_next;
    cpbc_pkg::loop_t               loop_reg, loop_next;
    logic [cpbc_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [cpbc_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                          vel_ran_reg, vel_ran_next;
    logic                          ang_ran_reg, ang_ran_next;
    logic                          m_valid_reg, m_valid_next;

    // Loop state
    logic signed [W-1:0] integ_reg [3];
    logic signed [W-1:0] integ_next [3];
    logic signed [W-1:0] last_reg [3];
    logic signed [W-1:0] last_next [3];
    logic signed [W-1:0] vel_out_reg, vel_out_next;
    logic signed [W-1:0] ang_out_reg, ang_out_next;

    // Configuration
    logic [cpbc_pkg::GAINS_W-1:0]       gains_reg [3];
    logic [cpbc_pkg::LIMIT_W-1:0]       limit_reg [3];
    logic signed [cpbc_pkg::ANGLE_W-1:0] balance_reg;

    // Working registers
    logic signed [cpbc_pkg::ANGLE_W-1:0] roll_reg, roll_next;
    logic signed [cpbc_pkg::GYRO_W-1:0]  gyro_reg, gyro_next;
    logic signed [cpbc_pkg::WHEEL_W-1:0] wheel_reg, wheel_next;
    logic signed [W-1:0] err_reg, err_next;
    logic signed [W-1:0] tmp_reg, tmp_next;
    logic signed [W-1:0] diff_reg, diff_next;
    logic signed [W-1:0] acc_reg, acc_next;
    logic [31:0]         m_data_reg, m_data_next;

    // Shared ALU hookup
    cpbc_pkg::alu_op_t            alu_op;
    logic signed [W-1:0]          alu_a;
    logic signed [W-1:0]          alu_b;
    logic signed [GW-1:0]         alu_gain;
    logic [cpbc_pkg::LIMIT_W-1:0] alu_lim;
    logic signed [W-1:0]          alu_y;

    cpbc_alu u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .gain (alu_gain),
        .lim  (alu_lim),
        .y    (alu_y)
    );

    logic [cpbc_pkg::GAINS_W-1:0]  cur_gains;
    logic signed [W-1:0]           wheel_scaled;
    logic signed [W-1:0]           gyro_scaled;
    logic [cpbc_pkg::TICK_W-1:0]   tick_inc;
    logic [cpbc_pkg::PHASE_W-1:0]  phase_inc;
    logic signed [W:0]             drive_q;
    logic [cpbc_pkg::DRIVE_W-1:0]  drive_sat;

    assign cur_gains    = gains_reg[loop_reg];
    assign wheel_scaled = W'(wheel_reg) <<< cpbc_pkg::FRAC_BITS;
    assign gyro_scaled  = W'(gyro_reg) <<< cpbc_pkg::FRAC_BITS;
    assign tick_inc     = tick_reg + 1'b1;
    assign phase_inc    = (phase_reg == cpbc_pkg::PHASE_W'(cpbc_pkg::ANGLE_PERIOD - 1)) ?
                          '0 : phase_reg + 1'b1;

    // Rate loop output to integer, truncated toward zero, then saturated
    always_comb begin
        drive_q = ((W + 1)'(acc_reg) +
                   (acc_reg[W-1] ? (W + 1)'(cpbc_pkg::FRAC_MASK) : (W + 1)'(0)))
                  >>> cpbc_pkg::FRAC_BITS;
        if (drive_q > (W + 1)'(cpbc_pkg::DRIVE_MAX)) begin
            drive_sat = cpbc_pkg::DRIVE_W'(cpbc_pkg::DRIVE_MAX);
        end else if (drive_q < (W + 1)'(cpbc_pkg::DRIVE_MIN)) begin
            drive_sat = cpbc_pkg::DRIVE_W'(cpbc_pkg::DRIVE_MIN);
        end else begin
            drive_sat = drive_q[cpbc_pkg::DRIVE_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        loop_next    = loop_reg;
        tick_next    = tick_reg;
        phase_next   = phase_reg;
        vel_ran_next = vel_ran_reg;
        ang_ran_next = ang_ran_reg;
        m_valid_next = m_valid_reg;
        integ_next   = integ_reg;
        last_next    = last_reg;
        vel_out_next = vel_out_reg;
        ang_out_next = ang_out_reg;
        roll_next    = roll_reg;
        gyro_next    = gyro_reg;
        wheel_next   = wheel_reg;
        err_next     = err_reg;
        tmp_next     = tmp_reg;
        diff_next    = diff_reg;
        acc_next     = acc_reg;
        m_data_next  = m_data_reg;

        alu_op   = cpbc_pkg::ALU_ADD;
        alu_a    = err_reg;
        alu_b    = tmp_reg;
        alu_gain = cur_gains[GW-1:0];
        alu_lim  = limit_reg[loop_reg];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    roll_next  = s_tdata[16:0];
                    gyro_next  = s_tdata[32:17];
                    wheel_next = s_tdata[48:33];
                    if (tick_inc == cpbc_pkg::TICK_W'(cpbc_pkg::VELOCITY_PERIOD)) begin
                        tick_next    = '0;
                        phase_next   = '0;
                        vel_ran_next = 1'b1;
                        ang_ran_next = 1'b1;
                        loop_next    = cpbc_pkg::LOOP_VEL;
                    end else begin
                        tick_next    = tick_inc;
                        phase_next   = phase_inc;
                        vel_ran_next = 1'b0;
                        ang_ran_next = (phase_inc == '0);
                        loop_next    = (phase_inc == '0) ? cpbc_pkg::LOOP_ANG :
                                                           cpbc_pkg::LOOP_RATE;
                    end
                    state_next = ST_ERR_A;
                end
            end

            ST_ERR_A: begin
                alu_op = cpbc_pkg::ALU_SUB;
                unique case (loop_reg)
                    cpbc_pkg::LOOP_VEL: begin
                        alu_a    = '0;
                        alu_b    = wheel_scaled;
                        err_next = alu_y;
                        state_next = ST_INTEG;
                    end
                    cpbc_pkg::LOOP_ANG: begin
                        alu_a    = vel_out_reg;
                        alu_b    = W'(roll_reg);
                        tmp_next = alu_y;
                        state_next = ST_ERR_B;
                    end
                    default: begin
                        alu_a    = ang_out_reg;
                        alu_b    = gyro_scaled;
                        err_next = alu_y;
                        state_next = ST_INTEG;
                    end
                endcase
            end

            ST_ERR_B: begin
                alu_a      = tmp_reg;
                alu_b      = W'(balance_reg);
                err_next   = alu_y;
                state_next = ST_INTEG;
            end

            ST_INTEG: begin
                alu_a      = integ_reg[loop_reg];
                alu_b      = err_reg;
                tmp_next   = alu_y;
                state_next = ST_CLAMP;
            end

            ST_CLAMP: begin
                alu_op = cpbc_pkg::ALU_CLAMP;
                alu_a  = tmp_reg;
                integ_next[loop_reg] = alu_y;
                state_next = ST_DIFF;
            end

            ST_DIFF: begin
                alu_op    = cpbc_pkg::ALU_SUB;
                alu_a     = err_reg;
                alu_b     = last_reg[loop_reg];
                diff_next = alu_y;
                last_next[loop_reg] = err_reg;
                state_next = ST_TERM_P;
            end

            ST_TERM_P: begin
                alu_op     = cpbc_pkg::ALU_MUL;
                alu_a      = err_reg;
                alu_gain   = cur_gains[GW-1:0];
                acc_next   = alu_y;
                state_next = ST_TERM_I;
            end

            ST_TERM_I: begin
                alu_op     = cpbc_pkg::ALU_MUL;
                alu_a      = integ_reg[loop_reg];
                alu_gain   = cur_gains[2*GW-1:GW];
                tmp_next   = alu_y;
                state_next = ST_SUM_PI;
            end

            ST_SUM_PI: begin
                alu_a      = acc_reg;
                alu_b      = tmp_reg;
                acc_next   = alu_y;
                state_next = ST_TERM_D;
            end

            ST_TERM_D: begin
                alu_op     = cpbc_pkg::ALU_MUL;
                alu_a      = diff_reg;
                alu_gain   = cur_gains[3*GW-1:2*GW];
                tmp_next   = alu_y;
                state_next = ST_SUM_D;
            end

            ST_SUM_D: begin
                alu_a = acc_reg;
                alu_b = tmp_reg;
                unique case (loop_reg)
                    cpbc_pkg::LOOP_VEL: begin
                        vel_out_next = alu_y;
                        loop_next    = ang_ran_reg ? cpbc_pkg::LOOP_ANG :
                                                     cpbc_pkg::LOOP_RATE;
                        state_next   = ST_ERR_A;
                    end
                    cpbc_pkg::LOOP_ANG: begin
                        ang_out_next = alu_y;
                        loop_next    = cpbc_pkg::LOOP_RATE;
                        state_next   = ST_ERR_A;
                    end
                    default: begin
                        acc_next   = alu_y;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DONE: begin
                // wait here only while the previous result is still unclaimed
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {6'b0, ang_ran_reg, vel_ran_reg, drive_sat};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            loop_reg    <= cpbc_pkg::LOOP_VEL;
            tick_reg    <= '0;
            phase_reg   <= '0;
            vel_ran_reg <= 1'b0;
            ang_ran_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vel_out_reg <= '0;
            ang_out_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                integ_reg[i] <= '0;
                last_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            loop_reg    <= loop_next;
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
            vel_ran_reg <= vel_ran_next;
            ang_ran_reg <= ang_ran_next;
            m_valid_reg <= m_valid_next;
            vel_out_reg <= vel_out_next;
            ang_out_reg <= ang_out_next;
            integ_reg   <= integ_next;
            last_reg    <= last_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                gains_reg[i] <= '0;
                limit_reg[i] <= '0;
            end
            balance_reg <= cpbc_pkg::BALANCE_RESET;
        end else if (cfg_wr_en) begin
            case (cpbc_pkg::cfg_reg_t'(cfg_addr))
                cpbc_pkg::REG_VEL_GAINS:  gains_reg[0] <= cfg_wr_data;
                cpbc_pkg::REG_ANG_GAINS:  gains_reg[1] <= cfg_wr_data;
                cpbc_pkg::REG_RATE_GAINS: gains_reg[2] <= cfg_wr_data;
                cpbc_pkg::REG_VEL_LIMIT:  limit_reg[0] <= cfg_wr_data[cpbc_pkg::LIMIT_W-1:0];
                cpbc_pkg::REG_ANG_LIMIT:  limit_reg[1] <= cfg_wr_data[cpbc_pkg::LIMIT_W-1:0];
                cpbc_pkg::REG_RATE_LIMIT: limit_reg[2] <= cfg_wr_data[cpbc_pkg::LIMIT_W-1:0];
                cpbc_pkg::REG_BALANCE:    balance_reg  <= cfg_wr_data[cpbc_pkg::ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload (no reset)
    always_ff @(posedge aclk) begin
        roll_reg   <= roll_next;
        gyro_reg   <= gyro_next;
        wheel_reg  <= wheel_next;
        err_reg    <= err_next;
        tmp_reg    <= tmp_next;
        diff_reg   <= diff_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    // Checks
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_reg < cpbc_pkg::TICK_W'(cpbc_pkg::VELOCITY_PERIOD))
        else $error("tick counter past velocity period");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_ERR_A))
        else $error("accepted request did not start the loop sequence");

    a_vel_implies_ang: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[24] || m_tdata[25]))
        else $error("velocity tick without angle update");

endmodule

`default_nettype wire
